// ===== hdl/hcbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Widths, result kinds, character codes and the hex digit decoder shared by
// the decoder core.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // Width of the chunk size accumulator and of the running body total.
   localparam int LEN_BITS   = 24;
   localparam int TOTAL_BITS = 32;
   // The total plus one chunk length needs one carry bit above the wider of the two.
   localparam int SUM_BITS   = ((LEN_BITS > TOTAL_BITS) ? LEN_BITS : TOTAL_BITS) + 1;

   localparam int KIND_BITS  = 2;
   localparam int BYTE_BITS  = 8;
   localparam int RLEN_BITS  = 32;

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type KIND_DATA = 2'd0;
   localparam kind_type KIND_SIZE = 2'd1;
   localparam kind_type KIND_END  = 2'd2;
   localparam kind_type KIND_BAD  = 2'd3;

   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [3:0] DIGIT_TEN    = 4'd10;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes one ASCII hex digit in either case.
   function automatic hex_digit_type hex_decode(input logic [7:0] ch);
      hex_digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_UPPER_A) + DIGIT_TEN;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_LOWER_A) + DIGIT_TEN;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP chunked body decoder core
// Parses chunk size lines of a chunked body, passes the chunk data through
// and reports chunk lengths, the total body length and malformed input.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  req_in_byte
//  rsp      out        rsp_valid/rsp_ready  rsp_kind, rsp_out_byte, rsp_length_value
//
//  One request per clock cycle is sustained while rsp is not stalled; a request passes
//  from the input register through the decode logic that updates the phase, size and
//  byte counters into the result register.
//  Requests that produce no result (CR, hex digits, trailer bytes, anything after
//  the end or an error) still pass through the decode stage.
//  Reset is synchronous and returns the decoder to the start of a size line.
//  A stall on rsp holds the result register and backs up into req_ready.
//
module http_chunked_body_decoder_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [hcbd_pkg::BYTE_BITS-1:0]     req_in_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [hcbd_pkg::KIND_BITS-1:0]     rsp_kind,
   output logic [hcbd_pkg::BYTE_BITS-1:0]     rsp_out_byte,
   output logic [hcbd_pkg::RLEN_BITS-1:0]     rsp_length_value
);

   localparam logic [2:0] PH_SIZE   = 3'd0;
   localparam logic [2:0] PH_DATA   = 3'd1;
   localparam logic [2:0] PH_TRAIL1 = 3'd2;
   localparam logic [2:0] PH_TRAIL2 = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_ERR    = 3'd5;

   localparam int LB = hcbd_pkg::LEN_BITS;
   localparam int TB = hcbd_pkg::TOTAL_BITS;
   localparam int SB = hcbd_pkg::SUM_BITS;

   // Input register.
   logic                          in_valid_ff, in_valid_in;
   logic [hcbd_pkg::BYTE_BITS-1:0] in_byte_ff;

   // Decoder state.
   logic [2:0]    phase_ff, phase_in;
   logic [LB-1:0] size_accum_ff, size_accum_in;
   logic [LB-1:0] bytes_left_ff, bytes_left_in;
   logic [TB-1:0] total_ff, total_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   hcbd_pkg::kind_type             rsp_kind_ff;
   logic [hcbd_pkg::BYTE_BITS-1:0] rsp_byte_ff;
   logic [hcbd_pkg::RLEN_BITS-1:0] rsp_len_ff;

   logic                           advance;
   logic                           res_valid;
   hcbd_pkg::kind_type             res_kind;
   logic [hcbd_pkg::BYTE_BITS-1:0] res_byte;
   logic [hcbd_pkg::RLEN_BITS-1:0] res_len;
   hcbd_pkg::hex_digit_type        digit;
   logic [SB-1:0]                  sum;
   logic                           sum_overflow;
   logic [LB-1:0]                  left_dec;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign digit        = hcbd_pkg::hex_decode(in_byte_ff);
   assign sum          = SB'(total_ff) + SB'(size_accum_ff);
   assign sum_overflow = (sum[SB-1:TB] != '0);
   assign left_dec     = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;

   always_comb begin
      phase_in      = phase_ff;
      size_accum_in = size_accum_ff;
      bytes_left_in = bytes_left_ff;
      total_in      = total_ff;
      res_valid     = 1'b0;
      res_kind      = hcbd_pkg::KIND_DATA;
      res_byte      = '0;
      res_len       = '0;
      unique case (phase_ff)
         PH_SIZE: begin
            if (in_byte_ff == hcbd_pkg::CHAR_CR) begin
               // Carriage returns are dropped anywhere on the size line.
            end else if (in_byte_ff == hcbd_pkg::CHAR_LF) begin
               size_accum_in = '0;
               res_valid     = 1'b1;
               if (size_accum_ff == '0) begin
                  phase_in = PH_DONE;
                  res_kind = hcbd_pkg::KIND_END;
                  res_len  = hcbd_pkg::RLEN_BITS'(total_ff);
               end else if (sum_overflow) begin
                  phase_in = PH_ERR;
                  res_kind = hcbd_pkg::KIND_BAD;
               end else begin
                  phase_in      = PH_DATA;
                  total_in      = sum[TB-1:0];
                  bytes_left_in = size_accum_ff;
                  res_kind      = hcbd_pkg::KIND_SIZE;
                  res_len       = hcbd_pkg::RLEN_BITS'(size_accum_ff);
               end
            end else if (!digit.valid || size_accum_ff[LB-1:LB-4] != 4'd0) begin
               // Not a hex digit, or one more digit would overflow the size.
               phase_in  = PH_ERR;
               res_valid = 1'b1;
               res_kind  = hcbd_pkg::KIND_BAD;
            end else begin
               size_accum_in = {size_accum_ff[LB-5:0], digit.value};
            end
         end
         PH_DATA: begin
            bytes_left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_TRAIL1;
            end
            res_valid = 1'b1;
            res_kind  = hcbd_pkg::KIND_DATA;
            res_byte  = in_byte_ff;
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            phase_in      = PH_SIZE;
            size_accum_in = '0;
         end
         default: begin
            // End of message and error are terminal until reset.
         end
      endcase
   end

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_SIZE;
         size_accum_ff <= '0;
         bytes_left_ff <= '0;
         total_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            size_accum_ff <= size_accum_in;
            bytes_left_ff <= bytes_left_in;
            total_ff      <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_len_ff  <= res_len;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_length_value = rsp_len_ff;

   // The end and error phases are never left.
   a_terminal_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_ERR) |=> $stable(phase_ff))
      else $error("decoder left a terminal phase");

   // While passing data there is always at least one byte outstanding.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != '0))
      else $error("data phase with no bytes left");

   // A held end of message result means the decoder has finished.
   a_end_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == hcbd_pkg::KIND_END) |-> (phase_ff == PH_DONE))
      else $error("end result without done phase");

   // A held ill-formed result means the decoder is in the error phase.
   a_bad_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == hcbd_pkg::KIND_BAD) |-> (phase_ff == PH_ERR))
      else $error("ill-formed result without error phase");

   // Only data results carry a payload byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != hcbd_pkg::KIND_DATA) |-> (rsp_byte_ff == '0))
      else $error("nonzero byte on a non-data result");

endmodule
`default_nettype wire
